@@ hdl/bodt_pkg.sv @@
// Package for the byte-op decision tree mapper.
// Holds sizes, slot operation codes, the row layout and the slot ALU function.
// No dependencies.
package bodt_pkg;

    // Tree size and slots per node
    localparam int NODES     = 128;
    localparam int SLOTS     = 4;
    localparam int NODE_W    = $clog2(NODES);
    localparam int ROWS      = 1 << NODE_W;

    // One slot is an operation code and a constant; a row holds all slots of a node
    localparam int OPC_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int SLOT_BITS = OPC_W + BYTE_W;
    localparam int ROW_W     = SLOTS * SLOT_BITS;

    // Slot operation codes
    localparam logic [OPC_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OPC_W-1:0] OP_AND    = 3'd1;
    localparam logic [OPC_W-1:0] OP_XOR    = 3'd2;
    localparam logic [OPC_W-1:0] OP_LSL    = 3'd3;
    localparam logic [OPC_W-1:0] OP_LSR    = 3'd4;
    localparam logic [OPC_W-1:0] OP_ASSIGN = 3'd5;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // Outcome of evaluating one node
    typedef struct packed {
        logic              leaf;      // last slot is assign
        logic [BYTE_W-1:0] leaf_byte; // constant of that slot
        logic              dir_ok;    // branch outcome is 0 or 1
        logic              dir;       // branch outcome
    } node_res_t;

    // Apply one slot to a byte; codes 6 and 7 pass the byte through
    function automatic logic [BYTE_W-1:0] apply_slot(input logic [BYTE_W-1:0] b,
                                                     input logic [OPC_W-1:0]  code,
                                                     input logic [BYTE_W-1:0] k);
        logic [BYTE_W-1:0] r;
        case (code)
            OP_ADD:    r = b + k;
            OP_AND:    r = b & k;
            OP_XOR:    r = b ^ k;
            OP_LSL:    r = (k >= 8'd8) ? '0 : (b << k[2:0]);
            OP_LSR:    r = (k >= 8'd8) ? '0 : (b >> k[2:0]);
            OP_ASSIGN: r = k;
            default:   r = b;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/bodt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bodt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bodt_node_eval.sv @@
// Evaluates one tree node: leaf test and the chain of slot operations.
// Depends on bodt_pkg.
module bodt_node_eval (
    input  logic [bodt_pkg::ROW_W-1:0]  row,
    input  logic [bodt_pkg::BYTE_W-1:0] byte_in,
    output bodt_pkg::node_res_t         res
);
    import bodt_pkg::*;

    logic [BYTE_W-1:0] chain [SLOTS+1];
    logic [OPC_W-1:0]  last_op;

    // Slots are applied in order, slot 0 first
    always_comb begin
        chain[0] = byte_in;
        for (int s = 0; s < SLOTS; s++) begin
            chain[s+1] = apply_slot(chain[s],
                                    row[s*SLOT_BITS +: OPC_W],
                                    row[s*SLOT_BITS + OPC_W +: BYTE_W]);
        end
    end

    assign last_op = row[(SLOTS-1)*SLOT_BITS +: OPC_W];

    // Leaf when the last slot assigns; otherwise branch on the outcome
    always_comb begin
        res.leaf      = (last_op == OP_ASSIGN);
        res.leaf_byte = row[(SLOTS-1)*SLOT_BITS + OPC_W +: BYTE_W];
        res.dir_ok    = (chain[SLOTS][BYTE_W-1:1] == '0);
        res.dir       = chain[SLOTS][0];
    end

endmodule

@@ hdl/byte_op_decision_tree_mapper.sv @@
// Top level of the byte-op decision tree mapper: control, row valid bits,
// node store and output register. Depends on bodt_pkg, bodt_ram, bodt_node_eval.
//
// Usage:
//  Input channel (s_valid/s_ready) carries one request. s_op = 0 loads one
//  slot (s_node_index, s_slot_index, s_slot_operation, s_slot_constant) and
//  gives no result; a load outside the table is dropped. s_op = 1 maps s_byte_in
//  through the tree and gives one result on the output channel
//  (m_valid/m_ready, m_mapped_byte, m_walk_error).
//  Each node is one row of a wide RAM with a registered read; the walk reads
//  one row and evaluates it in each cycle, one tree level per cycle.
//  Load: the row is read, then the merged row is written back.
//  Evaluate: the result follows a walk over up to 7 levels with 128 nodes;
//  s_ready returns with the result.
//  Reset (aresetn low, synchronous) clears the per-row valid bits, so every
//  node reads as all zero (all slots add 0) at once; no clearing pass.
//  If the receiver stalls, the result waits in the output register and loads
//  still go through; a finished evaluate holds in a one-entry buffer and
//  further requests wait until the output register frees up.
module byte_op_decision_tree_mapper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [6:0] s_node_index,
    input  logic [1:0] s_slot_index,
    input  logic [2:0] s_slot_operation,
    input  logic [7:0] s_slot_constant,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_mapped_byte,
    output logic       m_walk_error
);
    import bodt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LDWR = 4'b0010,
        ST_WALK = 4'b0100,
        ST_PUSH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [1:0]        slot_reg, slot_next;
    logic [OPC_W-1:0]  opc_reg, opc_next;
    logic [BYTE_W-1:0] const_reg, const_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [BYTE_W-1:0] hold_byte_reg, hold_byte_next;
    logic              hold_err_reg, hold_err_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic              m_err_reg, m_err_next;
    logic [ROWS-1:0]   row_valid_reg;
    logic              rd_valid_reg;

    logic [NODE_W-1:0] rd_addr;
    logic [ROW_W-1:0]  ram_rdata, row_data, wr_row;
    logic              wr_en;
    node_res_t         nres;
    logic [NODE_W:0]   child;
    logic              walk_done;
    logic [BYTE_W-1:0] walk_byte;
    logic              walk_err;
    logic              out_free;
    logic              s_fire;
    logic              load_ok;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_ok  = (32'(s_node_index) < NODES) && (32'(s_slot_index) < SLOTS);

    // Node store: one row per node
    bodt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (node_reg),
        .wdata (wr_row),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Rows never written since reset read as zero
    assign row_data = rd_valid_reg ? ram_rdata : '0;

    bodt_node_eval u_eval (
        .row     (row_data),
        .byte_in (byte_reg),
        .res     (nres)
    );

    // Next node and walk termination
    assign child = {node_reg, nres.dir};
    always_comb begin
        walk_done = 1'b1;
        walk_byte = '0;
        walk_err  = 1'b1;
        if (nres.leaf) begin
            walk_byte = nres.leaf_byte;
            walk_err  = 1'b0;
        end else if (nres.dir_ok && (32'(child) < NODES)) begin
            walk_done = 1'b0;
        end
    end

    // Read-modify-write merge for a load
    always_comb begin
        wr_row = row_data;
        for (int s = 0; s < SLOTS; s++) begin
            if (32'(slot_reg) == s) begin
                wr_row[s*SLOT_BITS +: SLOT_BITS] = {const_reg, opc_reg};
            end
        end
    end
    assign wr_en = (state_reg == ST_LDWR);

    // Read address: a load's row, the root, or the next child
    always_comb begin
        rd_addr = node_reg;
        case (state_reg)
            ST_IDLE: rd_addr = (s_op == REQ_EVAL) ? NODE_W'(1) : NODE_W'(s_node_index);
            ST_WALK: rd_addr = child[NODE_W-1:0];
            default: rd_addr = node_reg;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Control
    always_comb begin
        state_next     = state_reg;
        node_next      = node_reg;
        slot_next      = slot_reg;
        opc_next       = opc_reg;
        const_next     = const_reg;
        byte_next      = byte_reg;
        hold_byte_next = hold_byte_reg;
        hold_err_next  = hold_err_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_byte_next    = m_byte_reg;
        m_err_next     = m_err_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_op == REQ_EVAL) begin
                        node_next  = NODE_W'(1);
                        byte_next  = s_byte_in;
                        state_next = ST_WALK;
                    end else if (load_ok) begin
                        node_next  = NODE_W'(s_node_index);
                        slot_next  = s_slot_index;
                        opc_next   = s_slot_operation;
                        const_next = s_slot_constant;
                        state_next = ST_LDWR;
                    end
                end
            end
            ST_LDWR: begin
                state_next = ST_IDLE;
            end
            ST_WALK: begin
                if (!walk_done) begin
                    node_next = child[NODE_W-1:0];
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = walk_byte;
                    m_err_next   = walk_err;
                    state_next   = ST_IDLE;
                end else begin
                    hold_byte_next = walk_byte;
                    hold_err_next  = walk_err;
                    state_next     = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = hold_byte_reg;
                    m_err_next   = hold_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            rd_valid_reg <= row_valid_reg[rd_addr];
            if (wr_en) begin
                row_valid_reg[node_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        node_reg      <= node_next;
        slot_reg      <= slot_next;
        opc_reg       <= opc_next;
        const_reg     <= const_next;
        byte_reg      <= byte_next;
        hold_byte_reg <= hold_byte_next;
        hold_err_reg  <= hold_err_next;
        m_byte_reg    <= m_byte_next;
        m_err_reg     <= m_err_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_mapped_byte = m_byte_reg;
    assign m_walk_error  = m_err_reg;

`ifndef SYNTHESIS
    // An error result always carries a zero byte
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_walk_error |-> m_mapped_byte == '0)
        else $error("error result with nonzero byte");

    // The walk never sits on node 0 or past the table
    a_walk_node: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> node_reg != '0 && 32'(node_reg) < NODES)
        else $error("walk node out of range");

    // An evaluate needs at least one row read before a result appears
    a_eval_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == REQ_EVAL |=> !$rose(m_valid))
        else $error("result too early after evaluate");

    // A load never produces a result
    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == REQ_LOAD && !m_valid |=> !m_valid)
        else $error("result after a load");
`endif

endmodule

@@ sim/byte_op_decision_tree_mapper_tb.sv @@
// Testbench for byte_op_decision_tree_mapper: loads tree nodes and maps bytes
// through them, checking every result against a tree walk kept in the bench.
// Depends on bodt_pkg and the mapper RTL.
`timescale 1ns / 1ps

module byte_op_decision_tree_mapper_tb;
    import bodt_pkg::*;

    localparam int          RANDOM_ITEMS = 1050;
    localparam int          BURST_START  = 400;
    localparam int          BURST_END    = 600;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // Codes 6 and 7 have no operation behind them
    localparam logic [OPC_W-1:0] CODE_SPARE6 = 3'd6;
    localparam logic [OPC_W-1:0] CODE_SPARE7 = 3'd7;
    localparam logic [OPC_W-1:0] ALU_CODES [5] = '{OP_ADD, OP_AND, OP_XOR, OP_LSL, OP_LSR};

    typedef struct packed {
        logic [BYTE_W-1:0] mapped;
        logic              err;
    } map_result_t;

    // Mirror of the node store, plus the mapped bytes still owed by the block
    class byte_map_checker;
        logic [OPC_W-1:0]  node_ops    [NODES*SLOTS];
        logic [BYTE_W-1:0] node_consts [NODES*SLOTS];
        map_result_t       pending_maps [$];
        int                errors;

        function new();
            foreach (node_ops[i]) begin
                node_ops[i]    = OP_ADD;
                node_consts[i] = '0;
            end
            errors = 0;
        endfunction

        function logic [BYTE_W-1:0] slot_result(logic [BYTE_W-1:0] v,
                                                logic [OPC_W-1:0] code,
                                                logic [BYTE_W-1:0] k);
            case (code)
                OP_ADD:    return v + k;
                OP_AND:    return v & k;
                OP_XOR:    return v ^ k;
                OP_LSL:    return (k > 8'd7) ? 8'h00 : (v << k);
                OP_LSR:    return (k > 8'd7) ? 8'h00 : (v >> k);
                OP_ASSIGN: return k;
                default:   return v;
            endcase
        endfunction

        // Walk from the root; any exit other than a leaf is an error with byte 0
        function map_result_t walk_tree(logic [BYTE_W-1:0] b);
            int unsigned       node;
            int unsigned       base;
            logic [BYTE_W-1:0] v;
            map_result_t       r;
            r.mapped = '0;
            r.err    = 1'b1;
            node     = 1;
            while (node < NODES) begin
                base = node * SLOTS;
                if (node_ops[base + SLOTS - 1] == OP_ASSIGN) begin
                    r.mapped = node_consts[base + SLOTS - 1];
                    r.err    = 1'b0;
                    return r;
                end
                v = b;
                for (int s = 0; s < SLOTS; s++) begin
                    v = slot_result(v, node_ops[base + s], node_consts[base + s]);
                end
                if (v > 8'd1) return r;
                node = 2 * node + v;
            end
            return r;
        endfunction

        function void note_request(logic op, logic [6:0] node, logic [1:0] slot,
                                   logic [OPC_W-1:0] code, logic [BYTE_W-1:0] k,
                                   logic [BYTE_W-1:0] b);
            if (op == REQ_LOAD) begin
                // out-of-table loads are dropped
                if (node < NODES && slot < SLOTS) begin
                    node_ops[node * SLOTS + slot]    = code;
                    node_consts[node * SLOTS + slot] = k;
                end
            end else begin
                pending_maps.push_back(walk_tree(b));
            end
        endfunction

        function void check_result(logic [BYTE_W-1:0] mapped, logic err);
            map_result_t want;
            if (pending_maps.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result mapped_byte=%h walk_error=%b",
                             mapped, err);
                return;
            end
            want = pending_maps.pop_front();
            if (mapped !== want.mapped || err !== want.err) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: mapped_byte exp %h got %h, walk_error exp %b got %b",
                             want.mapped, mapped, want.err, err);
            end
        endfunction

        function int pending();
            return pending_maps.size();
        endfunction
    endclass

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic       s_op             = REQ_LOAD;
    logic [6:0] s_node_index     = '0;
    logic [1:0] s_slot_index     = '0;
    logic [2:0] s_slot_operation = OP_ADD;
    logic [7:0] s_slot_constant  = '0;
    logic [7:0] s_byte_in        = '0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic [7:0] m_mapped_byte;
    logic       m_walk_error;

    byte_map_checker sb;
    int              sent_count  = 0;
    bit              burst       = 1'b0;
    int unsigned     cycle_count = 0;

    byte_op_decision_tree_mapper u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_node_index     (s_node_index),
        .s_slot_index     (s_slot_index),
        .s_slot_operation (s_slot_operation),
        .s_slot_constant  (s_slot_constant),
        .s_byte_in        (s_byte_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mapped_byte    (m_mapped_byte),
        .m_walk_error     (m_walk_error)
    );

    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stalls, none during the burst window
    always @(posedge aclk) begin
        m_ready <= burst || ($urandom_range(0, 99) >= 24);
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_mapped_byte, m_walk_error);
    end

    // Present one request, idling at random first, and wait for accept
    task automatic send_request(input logic op, input logic [6:0] node,
                                input logic [1:0] slot, input logic [2:0] code,
                                input logic [7:0] k, input logic [7:0] b);
        burst = (sent_count >= BURST_START && sent_count < BURST_END);
        while (!burst && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= op;
        s_node_index     <= node;
        s_slot_index     <= slot;
        s_slot_operation <= code;
        s_slot_constant  <= k;
        s_byte_in        <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(op, node, slot, code, k, b);
        sent_count++;
    endtask

    // Unused fields carry random values
    task automatic load_slot(input int node, input int slot, input logic [2:0] code,
                             input logic [7:0] k);
        send_request(REQ_LOAD, node[6:0], slot[1:0], code, k, 8'($urandom));
    endtask

    task automatic map_byte(input logic [7:0] b);
        send_request(REQ_EVAL, 7'($urandom), 2'($urandom), 3'($urandom), 8'($urandom), b);
    endtask

    function automatic logic [2:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 15) return ALU_CODES[r % 5];
        if (r < 17) return OP_ASSIGN;
        return (r < 19) ? CODE_SPARE6 : CODE_SPARE7;
    endfunction

    // Shift amounts stay mostly in 0 to 9, around the 8-bit boundary
    function automatic logic [7:0] pick_const(input logic [2:0] code);
        if ((code == OP_LSL || code == OP_LSR) && $urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 9));
        return 8'($urandom);
    endfunction

    // Inner node: random slots, last slot usually forces the outcome to 0 or 1
    task automatic load_inner(input int node);
        int unsigned r;
        logic [2:0]  code;
        for (int s = 0; s < SLOTS - 1; s++) begin
            code = pick_code();
            load_slot(node, s, code, pick_const(code));
        end
        r = $urandom_range(0, 9);
        if (r < 5) begin
            load_slot(node, SLOTS - 1, OP_AND, 8'h01);
        end else if (r < 8) begin
            load_slot(node, SLOTS - 1, OP_LSR, 8'd7);
        end else begin
            code = pick_code();
            if (code == OP_ASSIGN) code = OP_XOR;
            load_slot(node, SLOTS - 1, code, pick_const(code));
        end
    endtask

    // Leaf: assign in the last slot, other slots sometimes scribbled
    task automatic load_leaf(input int node);
        logic [2:0] code;
        if ($urandom_range(0, 3) == 0) begin
            for (int s = 0; s < SLOTS - 1; s++) begin
                code = pick_code();
                load_slot(node, s, code, pick_const(code));
            end
        end
        load_slot(node, SLOTS - 1, OP_ASSIGN, 8'($urandom));
    endtask

    initial begin
        int          depth;
        int          node;
        int          target;
        int unsigned r;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Cleared store: all-add nodes, walks run off the table or branch above one
        map_byte(8'h00);
        map_byte(8'h01);
        map_byte(8'hFF);

        // Leaf at the root
        load_slot(1, SLOTS - 1, OP_ASSIGN, 8'hA5);
        map_byte(8'h00);

        // Table extremes
        load_slot(0, 0, CODE_SPARE7, 8'hFF);
        load_slot(NODES - 1, SLOTS - 1, OP_LSR, 8'h80);

        // Root branches on the top bit of (b - 1) ^ 0x80, spare code in last slot
        load_slot(1, 0, OP_ADD, 8'hFF);
        load_slot(1, 1, OP_XOR, 8'h80);
        load_slot(1, 2, OP_LSR, 8'd7);
        load_slot(1, 3, CODE_SPARE6, 8'h00);
        // Wide shift, then assign mid-node, always go right
        load_slot(2, 0, OP_LSL, 8'd8);
        load_slot(2, 1, OP_ASSIGN, 8'h01);
        load_slot(2, 2, OP_AND, 8'hFF);
        load_slot(2, 3, CODE_SPARE7, 8'h00);
        load_slot(3, SLOTS - 1, OP_ASSIGN, 8'hFF);
        load_slot(5, SLOTS - 1, OP_ASSIGN, 8'h00);
        map_byte(8'h00);
        map_byte(8'h7F);
        map_byte(8'h80);
        map_byte(8'hFF);

        // Random rounds: build a tree (full and shallow, or one deep path), then map
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            if ($urandom_range(0, 7) != 0) begin
                depth = $urandom_range(1, 4);
                for (int n = 1; n < (2 << depth); n++) begin
                    if (n < (1 << depth)) load_inner(n);
                    else load_leaf(n);
                end
            end else begin
                depth = $urandom_range(5, 7);
                node  = 1;
                for (int lv = 0; lv < depth; lv++) begin
                    load_inner(node);
                    if (lv > 0) load_leaf(node ^ 1);
                    node = 2 * node + $urandom_range(0, 1);
                end
                if (node < NODES) load_leaf(node);
            end
            repeat ($urandom_range(20, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    load_slot($urandom_range(0, NODES - 1), $urandom_range(0, SLOTS - 1),
                              3'($urandom), 8'($urandom));
                else if (r < 16)
                    map_byte(8'h00);
                else if (r < 24)
                    map_byte(8'hFF);
                else
                    map_byte(8'($urandom));
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
